// ----- rtl/hpr_pkg.sv -----
package hpr_pkg;

  // Default configuration of the block.
  localparam int unsigned DEF_MAX_ELEMENTS = 64;
  localparam int unsigned DEF_VALUE_WIDTH  = 32;

  // Fixed widths of the channel payloads.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned SPLIT_W = 7;

  // Source of the store read address.
  typedef enum logic [1:0] {
    RD_SEL_I = 2'd0,
    RD_SEL_J = 2'd1,
    RD_SEL_K = 2'd2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    rd_sel_e rd_sel;
    logic    inc_i;
    logic    dec_j;
    logic    latch_a;
    logic    latch_b;
    logic    wr_i;
    logic    wr_j;
    logic    init_emit;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic load_close;
    logic i_adv;
    logic j_adv;
    logic ptr_meet;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/hpr_in_if.sv -----
interface hpr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

// ----- rtl/hpr_out_if.sv -----
interface hpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_out;
  logic [5:0]         position;
  logic [6:0]         split_point;
  logic               run_last;

  modport source (output valid, output element_out, output position, output split_point,
                  output run_last, input ready);
  modport sink   (input valid, input element_out, input position, input split_point,
                  input run_last, output ready);
endinterface

// ----- rtl/hpr_ctrl.sv -----
module hpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hpr_pkg::status_t status_i,
  output hpr_pkg::cmd_t    cmd_o
);
  import hpr_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_RD_I   = 9'b000000010,
    S_CMP_I  = 9'b000000100,
    S_RD_J   = 9'b000001000,
    S_CMP_J  = 9'b000010000,
    S_SW_I   = 9'b000100000,
    S_SW_J   = 9'b001000000,
    S_EM_RD  = 9'b010000000,
    S_EM_OUT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_SEL_I;
    state_d      = state_q;
    case (state_q)
      S_LOAD: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid && status_i.load_close) begin
          state_d = S_RD_I;
        end
      end
      S_RD_I: begin
        state_d = S_CMP_I;
      end
      S_CMP_I: begin
        if (status_i.i_adv) begin
          cmd_o.inc_i = 1'b1;
          state_d     = S_RD_I;
        end else begin
          cmd_o.latch_a = 1'b1;
          state_d       = S_RD_J;
        end
      end
      S_RD_J: begin
        cmd_o.rd_sel = RD_SEL_J;
        state_d      = S_CMP_J;
      end
      S_CMP_J: begin
        cmd_o.rd_sel = RD_SEL_J;
        if (status_i.j_adv) begin
          cmd_o.dec_j = 1'b1;
          state_d     = S_RD_J;
        end else begin
          cmd_o.latch_b = 1'b1;
          if (status_i.ptr_meet) begin
            cmd_o.init_emit = 1'b1;
            state_d         = S_EM_RD;
          end else begin
            state_d = S_SW_I;
          end
        end
      end
      S_SW_I: begin
        cmd_o.wr_i = 1'b1;
        state_d    = S_SW_J;
      end
      S_SW_J: begin
        cmd_o.wr_j  = 1'b1;
        cmd_o.inc_i = 1'b1;
        cmd_o.dec_j = 1'b1;
        state_d     = S_RD_I;
      end
      S_EM_RD: begin
        cmd_o.rd_sel = RD_SEL_K;
        state_d      = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd_o.rd_sel = RD_SEL_K;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.emit_last ? S_LOAD : S_EM_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/hpr_datapath.sv -----
module hpr_datapath #(
  parameter int unsigned MAX_ELEMENTS = hpr_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned VALUE_WIDTH  = hpr_pkg::DEF_VALUE_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  hpr_pkg::cmd_t    cmd_i,
  output hpr_pkg::status_t status_o,
  hpr_in_if.sink           in_chan,
  hpr_out_if.source        out_chan
);
  import hpr_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned ExtW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

  logic signed [VALUE_WIDTH-1:0] mem_q [MAX_ELEMENTS];
  logic signed [VALUE_WIDTH-1:0] rdata_q, piv_q, a_q, b_q;
  logic signed [VALUE_WIDTH-1:0] in_value, wdata;
  logic signed [ExtW-1:0]        rd_ext;
  logic [CntW-1:0]               fill_q, n_q, n_m1;
  logic [IdxW-1:0]               i_q, j_q, k_q, raddr, waddr;
  logic                          ascend_q, out_valid_q, load_fire, we;
  logic signed [DATA_W-1:0]      elem_q;
  logic [POS_W-1:0]              pos_q;
  logic [SPLIT_W-1:0]            split_q;
  logic                          last_q;

  function automatic logic precedes(input logic signed [VALUE_WIDTH-1:0] a,
                                    input logic signed [VALUE_WIDTH-1:0] b,
                                    input logic asc);
    return asc ? (a < b) : (a > b);
  endfunction

  assign in_value  = VALUE_WIDTH'($unsigned(in_chan.sample_value));
  assign load_fire = in_chan.valid && cmd_i.in_ready;
  assign n_m1      = n_q - CntW'(1);

  assign in_chan.ready = cmd_i.in_ready;

  assign status_o.in_valid   = in_chan.valid;
  assign status_o.load_close = in_chan.end_of_set || (fill_q == CntW'(MAX_ELEMENTS - 1));
  assign status_o.i_adv      = (CntW'(i_q) < n_m1) && precedes(rdata_q, piv_q, ascend_q);
  assign status_o.j_adv      = (j_q != '0) && precedes(piv_q, rdata_q, ascend_q);
  assign status_o.ptr_meet   = (j_q <= i_q);
  assign status_o.emit_last  = (CntW'(k_q) == n_m1);
  assign status_o.out_free   = !out_valid_q || out_chan.ready;

  // Store ports: one write and one registered read per cycle.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_SEL_I: raddr = i_q;
      RD_SEL_J: raddr = j_q;
      RD_SEL_K: raddr = k_q;
      default:  raddr = i_q;
    endcase
    we = load_fire || cmd_i.wr_i || cmd_i.wr_j;
    if (load_fire) begin
      waddr = fill_q[IdxW-1:0];
      wdata = in_value;
    end else if (cmd_i.wr_i) begin
      waddr = i_q;
      wdata = b_q;
    end else begin
      waddr = j_q;
      wdata = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load_fire && (fill_q == '0)) begin
      piv_q <= in_value;
    end
    if (cmd_i.latch_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.latch_b) begin
      b_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      ascend_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        ascend_q <= cfg_data_i;
      end
      if (load_fire) begin
        if (status_o.load_close) begin
          fill_q <= '0;
          n_q    <= fill_q + CntW'(1);
          i_q    <= '0;
          j_q    <= fill_q[IdxW-1:0];
        end else begin
          fill_q <= fill_q + CntW'(1);
        end
      end
      if (cmd_i.inc_i) begin
        i_q <= i_q + IdxW'(1);
      end
      if (cmd_i.dec_j) begin
        j_q <= j_q - IdxW'(1);
      end
      if (cmd_i.init_emit) begin
        k_q <= '0;
      end else if (cmd_i.out_load) begin
        k_q <= k_q + IdxW'(1);
      end
    end
  end

  // Output register.
  assign rd_ext = ExtW'(rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      elem_q  <= rd_ext[DATA_W-1:0];
      pos_q   <= POS_W'(k_q);
      split_q <= SPLIT_W'(j_q) + SPLIT_W'(1);
      last_q  <= status_o.emit_last;
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.element_out = elem_q;
  assign out_chan.position    = pos_q;
  assign out_chan.split_point = split_q;
  assign out_chan.run_last    = last_q;

endmodule

// ----- rtl/hoare_partition_real.sv -----
// Channel   Direction  Handshake     Word contents
// in_chan   in         valid/ready   sample_value, end_of_set
// out_chan  out        valid/ready   element_out, position, split_point, run_last
// cfg       in         cfg_we_i      cfg_data_i -> ascend_order
//
// A set of n words is loaded at one word per cycle. Each partitioning pointer step
// reads the store, then compares, and each swap writes the two elements in turn, as
// the element store has one registered read port and one write port. Emission reads
// each word from the store, then registers it; the sink stalls it by holding ready low.
// Reset is asynchronous and active low; it empties the store fill and sets
// ascending order. The store itself is not cleared. Input ready is high only
// while a set is loading; the next set may load while the last word still waits.
module hoare_partition_real #(
  parameter int unsigned MAX_ELEMENTS = hpr_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned VALUE_WIDTH  = hpr_pkg::DEF_VALUE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  hpr_in_if.sink    in_chan,
  hpr_out_if.source out_chan
);
  import hpr_pkg::*;

  // The controller sequences load, scan, swap and emit; the datapath holds the
  // element store, the pointers, the pivot and the output register.
  cmd_t    cmd;
  status_t st;

  hpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (st),
    .cmd_o    (cmd)
  );

  hpr_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (st),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  // Loading and emitting never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.in_ready |-> !cmd.out_load)
    else $error("input accepted while a word is emitted");

  // The store has a single write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_i, cmd.wr_j, in_chan.valid && in_chan.ready}))
    else $error("more than one store write in a cycle");

  // Closing a set stops loading until the set is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan.valid && in_chan.ready && st.load_close) |=> !in_chan.ready)
    else $error("input still ready after the set was closed");

  // A swap write is always followed by its partner write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_i |=> cmd.wr_j)
    else $error("swap left half done");

endmodule
